// ===== design/swpwm_pkg.sv =====
`default_nettype none

package swpwm_pkg;

	// Field widths
	localparam int PERIOD_W   = 19;
	localparam int SLOT_IN_W  = 5;
	localparam int LEVELS_W   = 32;
	localparam int STATUS_W   = 2;
	localparam int CFG_IDX_W  = 1;

	// Defaults
	localparam int DEF_NUM_SLOTS = 8;
	localparam int RST_PERIOD    = 2000;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INVERT = 1'd1;

	// Item functions
	localparam logic FUNC_TICK = 1'b0;
	localparam logic FUNC_SET  = 1'b1;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_WIDE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_SLOT = 2'd2;

	// One input beat
	typedef struct packed {
		logic                 func;
		logic [SLOT_IN_W-1:0] slot;
		logic [PERIOD_W-1:0]  width;
	} item_t;

endpackage

`default_nettype wire

// ===== design/swpwm_cfg.sv =====
`default_nettype none

module swpwm_cfg #(
	parameter int NUM_SLOTS = swpwm_pkg::DEF_NUM_SLOTS
) (
	input  wire logic                                      clk,
	input  wire logic                                      arst_n,
	input  wire logic                                      cfg_we,
	input  wire logic [swpwm_pkg::CFG_IDX_W-1:0]           cfg_index,
	input  wire logic [swpwm_pkg::PERIOD_W-1:0]            cfg_wdata,
	output logic      [swpwm_pkg::PERIOD_W-1:0]            period,
	output logic                                           invert,
	output logic      [NUM_SLOTS-1:0][swpwm_pkg::PERIOD_W-1:0] starts,
	output logic                                           settle
);
	import swpwm_pkg::*;

	// Reciprocal for the period / NUM_SLOTS split, exact for every 19-bit period
	localparam int SHIFT  = PERIOD_W + $clog2(NUM_SLOTS);
	localparam int PROD_W = SHIFT + PERIOD_W + 1;
	localparam longint unsigned RECIP =
		((64'd1 << SHIFT) + 64'(NUM_SLOTS) - 64'd1) / 64'(NUM_SLOTS);
	localparam int RST_SPACING = RST_PERIOD / NUM_SLOTS;

	logic [PERIOD_W-1:0] period_q;
	logic [PERIOD_W-1:0] spacing_q;
	logic                invert_q;
	logic                settle_q;
	logic [NUM_SLOTS-1:0][PERIOD_W-1:0] start_q;

	logic [PERIOD_W-1:0] eff_wdata;
	logic [PROD_W-1:0]   spacing_prod;

	// Treat a zero period as one step
	assign eff_wdata    = (cfg_wdata == '0) ? PERIOD_W'(1) : cfg_wdata;
	assign spacing_prod = PROD_W'(eff_wdata) * PROD_W'(RECIP);

	// Capture register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q  <= PERIOD_W'(RST_PERIOD);
			spacing_q <= PERIOD_W'(RST_SPACING);
			invert_q  <= 1'b0;
			settle_q  <= 1'b0;
		end else begin
			settle_q <= cfg_we && (cfg_index == REG_PERIOD);
			if (cfg_we) begin
				case (cfg_index)
					REG_PERIOD: begin
						period_q  <= eff_wdata;
						spacing_q <= spacing_prod[SHIFT +: PERIOD_W];
					end
					REG_INVERT: invert_q <= cfg_wdata[0];
					default: ;
				endcase
			end
		end
	end

	// Rebuild slot start steps in the cycle after a period write
	for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_start
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				start_q[k] <= PERIOD_W'(k * RST_SPACING);
			end else if (settle_q) begin
				start_q[k] <= PERIOD_W'(PERIOD_W'(k) * spacing_q);
			end
		end
	end

	assign period = period_q;
	assign invert = invert_q;
	assign starts = start_q;
	assign settle = settle_q;

	// The last slot always starts inside the period once the starts are settled
	a_start_in_period: assert property (@(posedge clk) disable iff (!arst_n)
		!settle_q |-> (start_q[NUM_SLOTS-1] < period_q))
		else $error("slot start beyond period");

endmodule

`default_nettype wire

// ===== design/swpwm_core.sv =====
`default_nettype none

module swpwm_core #(
	parameter int NUM_SLOTS = swpwm_pkg::DEF_NUM_SLOTS
) (
	input  wire logic                                          clk,
	input  wire logic                                          arst_n,
	input  wire logic                                          advance,
	input  wire swpwm_pkg::item_t                              item,
	input  wire logic      [swpwm_pkg::PERIOD_W-1:0]           period,
	input  wire logic                                          invert,
	input  wire logic      [NUM_SLOTS-1:0][swpwm_pkg::PERIOD_W-1:0] starts,
	output logic           [swpwm_pkg::LEVELS_W-1:0]           levels_c,
	output logic           [swpwm_pkg::PERIOD_W-1:0]           phase_c,
	output logic           [swpwm_pkg::STATUS_W-1:0]           status_c
);
	import swpwm_pkg::*;

	localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

	logic [PERIOD_W-1:0]  phase_q;
	logic [NUM_SLOTS-1:0] level_q;
	logic [PERIOD_W-1:0]  act_q  [NUM_SLOTS];
	logic [PERIOD_W-1:0]  pend_q [NUM_SLOTS];

	logic [PERIOD_W-1:0]  ph;
	logic [PERIOD_W-1:0]  ph_next;
	logic [PERIOD_W-1:0]  aw_c [NUM_SLOTS];
	logic [NUM_SLOTS-1:0] hit_c;
	logic [NUM_SLOTS-1:0] lv_c;
	logic [NUM_SLOTS-1:0] lv_out;
	logic                 slot_ok;
	logic [SLOT_W-1:0]    slot_idx;
	logic                 is_tick;

	assign is_tick  = (item.func == FUNC_TICK);
	assign slot_ok  = ({1'b0, item.slot} < (SLOT_IN_W+1)'(NUM_SLOTS));
	assign slot_idx = item.slot[SLOT_W-1:0];

	// Wrap the phase if the period shrank under it
	assign ph      = (phase_q >= period) ? '0 : phase_q;
	assign ph_next = ((PERIOD_W+1)'(ph) + 1'b1 >= (PERIOD_W+1)'(period)) ? '0
	                                                                    : ph + 1'b1;

	// Per-slot start load and level compare
	always_comb begin
		logic [PERIOD_W:0] off;
		for (int k = 0; k < NUM_SLOTS; k++) begin
			hit_c[k] = (ph == starts[k]);
			aw_c[k]  = hit_c[k] ? pend_q[k] : act_q[k];
			if (ph >= starts[k]) begin
				off = {1'b0, ph} - {1'b0, starts[k]};
			end else begin
				off = {1'b0, ph} + {1'b0, period} - {1'b0, starts[k]};
			end
			lv_c[k] = (off < {1'b0, aw_c[k]});
		end
	end

	assign lv_out = invert ? ~lv_c : lv_c;

	// Result of the current beat
	always_comb begin
		if (is_tick) begin
			levels_c = LEVELS_W'(lv_out);
			phase_c  = ph;
			status_c = ST_OK;
		end else begin
			levels_c = LEVELS_W'(level_q);
			phase_c  = phase_q;
			if (!slot_ok) begin
				status_c = ST_SLOT;
			end else if (item.width > period) begin
				status_c = ST_WIDE;
			end else begin
				status_c = ST_OK;
			end
		end
	end

	// Advance the phase and levels on a tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			level_q <= '0;
		end else if (advance && is_tick) begin
			phase_q <= ph_next;
			level_q <= lv_out;
		end
	end

	// Load active widths at slot start, write shadows on a good set beat
	for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_slot
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				act_q[k]  <= '0;
				pend_q[k] <= '0;
			end else if (advance) begin
				if (is_tick && hit_c[k]) begin
					act_q[k] <= pend_q[k];
				end
				if (!is_tick && (status_c == ST_OK) && (slot_idx == SLOT_W'(k))) begin
					pend_q[k] <= item.width;
				end
			end
		end
	end

	a_phase_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && is_tick) |=> (phase_q < period))
		else $error("phase left the period after a tick");

	a_tick_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && is_tick) |-> (status_c == ST_OK))
		else $error("tick beat reported an error status");

endmodule

`default_nettype wire

// ===== design/staggered_multichannel_pwm.sv =====
`default_nettype none

// Channel  Handshake              Payload
// in       in_valid / in_ready    func, slot, width
// out      out_valid / out_ready  levels, phase, status
// cfg      cfg_we                 cfg_index, cfg_wdata
//
// One beat per clock when not stalled; the input register takes a beat at acceptance
// and its result lands in the result register on advance, after a single compare pass.
// Reset: period 2000, invert off, phase and all slot widths zero.
// in_ready drops for one cycle after a period write while slot starts reload.
// A stalled output holds its beat; the input register takes one more, then
// in_ready stays low until out_ready frees the result register.

module staggered_multichannel_pwm #(
	parameter int NUM_SLOTS = swpwm_pkg::DEF_NUM_SLOTS
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [swpwm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [swpwm_pkg::PERIOD_W-1:0]     cfg_wdata,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic                               func,
	input  wire logic [swpwm_pkg::SLOT_IN_W-1:0]    slot,
	input  wire logic [swpwm_pkg::PERIOD_W-1:0]     width,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic      [swpwm_pkg::LEVELS_W-1:0]     levels,
	output logic      [swpwm_pkg::PERIOD_W-1:0]     phase,
	output logic      [swpwm_pkg::STATUS_W-1:0]     status
);
	import swpwm_pkg::*;

	logic [PERIOD_W-1:0] period;
	logic                invert;
	logic [NUM_SLOTS-1:0][PERIOD_W-1:0] starts;
	logic                settle;

	item_t               item_s1;
	logic                valid_s1;
	logic                advance;
	logic                out_valid_q;
	logic [LEVELS_W-1:0] levels_q;
	logic [PERIOD_W-1:0] phase_q;
	logic [STATUS_W-1:0] status_q;

	logic [LEVELS_W-1:0] levels_c;
	logic [PERIOD_W-1:0] phase_c;
	logic [STATUS_W-1:0] status_c;

	swpwm_cfg #(.NUM_SLOTS(NUM_SLOTS)) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.period    (period),
		.invert    (invert),
		.starts    (starts),
		.settle    (settle)
	);

	swpwm_core #(.NUM_SLOTS(NUM_SLOTS)) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.item     (item_s1),
		.period   (period),
		.invert   (invert),
		.starts   (starts),
		.levels_c (levels_c),
		.phase_c  (phase_c),
		.status_c (status_c)
	);

	// Move the input beat on when the result register is free
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = (!valid_s1 || advance) && !settle;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= '{func: func, slot: slot, width: width};
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			levels_q <= levels_c;
			phase_q  <= phase_c;
			status_q <= status_c;
		end
	end

	assign out_valid = out_valid_q;
	assign levels    = levels_q;
	assign phase     = phase_q;
	assign status    = status_q;

	a_unused_levels_low: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((64'(levels_q) >> NUM_SLOTS) == 64'd0))
		else $error("level bit set above the slot count");

endmodule

`default_nettype wire
